// File: rtl/rddp_pkg.sv
// Shared types, constants and helper functions for the register dependency distance profiler.
package rddp_pkg;

  localparam int NUM_REGS_DEF  = 64;
  localparam int HIST_BINS_DEF = 128;

  localparam int MODE_W    = 3;
  localparam int REG_W     = 6;
  localparam int BIN_W     = 7;
  localparam int SPACING_W = 7;
  localparam int COUNT_W   = 32;
  localparam int TIME_W    = 64;

  localparam logic [SPACING_W-1:0] MAX_SPACING_RST = 7'd100;

  localparam logic [MODE_W-1:0] MODE_SRC_READ  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DST_WRITE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_BIN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_TAIL = 3'd4;

  // x/5 for a 7-bit x equals (x * 205) >> 10.
  localparam int DIV5_MUL   = 205;
  localparam int DIV5_SHIFT = 10;
  localparam int DIV5_PW    = SPACING_W + DIV5_SHIFT;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REG_W-1:0]  reg_index;
    logic [BIN_W-1:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic [SPACING_W-1:0] distance;
    logic                 is_tail;
    logic [COUNT_W-1:0]   read_value;
    logic [REG_W-1:0]     top_tail_reg;
    logic [COUNT_W-1:0]   top_tail_count;
  } out_item_t;

  function automatic logic [COUNT_W-1:0] sat_inc32(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + COUNT_W'(1);
  endfunction

  // Tail threshold is (max_spacing / 5) * 4.
  function automatic logic [SPACING_W-1:0] tail_threshold(input logic [SPACING_W-1:0] ms);
    logic [DIV5_PW-1:0]   prod;
    logic [SPACING_W-1:0] quo;
    prod = DIV5_PW'(ms) * DIV5_PW'(DIV5_MUL);
    quo  = prod[DIV5_PW-1:DIV5_SHIFT];
    return {quo[SPACING_W-3:0], 2'b00};
  endfunction

endpackage

// File: rtl/rddp_table.sv
// Zero-initialized table: one write port, one registered read port with per-entry valid bits.
module rddp_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] data_r;
  logic             data_vld_r;
  logic             bypass;

  // A write in the same cycle as a read of the same entry is returned directly.
  assign bypass = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= bypass ? wr_data : mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      data_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        data_vld_r <= bypass || vld_r[rd_addr];
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // An entry never written since reset reads as zero.
  assign rd_data = data_vld_r ? data_r : '0;

endmodule

// File: rtl/register_dependency_distance_profiler.sv
// Register dependency distance profiler: top level with the two-stage event pipeline.
// One event is accepted every cycle unless in_stall is high, as when stage one is full and
// out_stall holds stage two. Each result is held in the output register while out_stall is
// high. Stage one holds the event with the last-write time and tail count read for it and
// updates the instruction counter, the last-write table, the tail counts and the top-tail
// tracker. Stage two holds the histogram bin read and is the output register; the bin
// increment is written back when the result transaction completes. Each table has one read
// and one write port, and a read of an entry written in the same cycle is forwarded, which is
// what keeps the rate at one per cycle.
// Tables read as zero after reset through per-entry valid bits, so no clearing pass is needed.
module register_dependency_distance_profiler #(
  parameter int NUM_REGS  = rddp_pkg::NUM_REGS_DEF,
  parameter int HIST_BINS = rddp_pkg::HIST_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rddp_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rddp_pkg::out_item_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [rddp_pkg::SPACING_W-1:0]     cfg_wr_data
);

  localparam int REG_AW  = $clog2(NUM_REGS);
  localparam int HIST_AW = $clog2(HIST_BINS);

  typedef struct packed {
    logic [rddp_pkg::SPACING_W-1:0] distance;
    logic                           is_tail;
    logic [rddp_pkg::COUNT_W-1:0]   read_value;
    logic                           hist_inc;
    logic                           hist_rd;
    logic [HIST_AW-1:0]             hist_addr;
    logic [REG_AW-1:0]              best_reg;
    logic [rddp_pkg::COUNT_W-1:0]   best_cnt;
  } s2_stage_t;

  logic [rddp_pkg::SPACING_W-1:0] max_spacing_r;
  logic [rddp_pkg::TIME_W-1:0]    instr_time_r, instr_time_nxt;
  logic [REG_AW-1:0]              best_reg_r, best_reg_nxt;
  logic [rddp_pkg::COUNT_W-1:0]   best_cnt_r, best_cnt_nxt;

  logic                s1_vld_r, s1_vld_nxt;
  rddp_pkg::in_item_t  s1_r;
  logic                s2_vld_r, s2_vld_nxt;
  s2_stage_t           s2_r, s2_nxt;

  logic in_fire, s1_adv, s2_free, out_fire;

  logic [REG_AW-1:0]              in_reg_idx, s1_reg_idx;
  logic                           s1_reg_ok, s1_bin_ok;
  logic [rddp_pkg::TIME_W-1:0]    lw_rd_data;
  logic [rddp_pkg::COUNT_W-1:0]   tail_rd_data, hist_rd_data;
  logic [rddp_pkg::TIME_W-1:0]    diff;
  logic [rddp_pkg::SPACING_W-1:0] dist_sat, thr;
  logic [rddp_pkg::COUNT_W-1:0]   tail_cnt_inc;
  logic                           tail_hit, best_upd;
  logic                           lw_we;
  logic [HIST_AW-1:0]             slot;

  // Handshake and pipeline occupancy.
  assign out_fire  = s2_vld_r && !out_stall;
  assign s2_free   = !s2_vld_r || !out_stall;
  assign s1_adv    = s1_vld_r && s2_free;
  assign in_stall  = s1_vld_r && !s2_free;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = s2_vld_r;

  assign s1_vld_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
  assign s2_vld_nxt = s1_adv ? 1'b1 : (out_fire ? 1'b0 : s2_vld_r);

  assign in_reg_idx = REG_AW'(in_data.reg_index);
  assign s1_reg_idx = REG_AW'(s1_r.reg_index);
  assign s1_reg_ok  = 32'(s1_r.reg_index) < NUM_REGS;
  assign s1_bin_ok  = 32'(s1_r.bin_index) < HIST_BINS;

  rddp_table #(.DEPTH(NUM_REGS), .WIDTH(rddp_pkg::TIME_W)) u_last_write (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_reg_idx),
    .rd_data (lw_rd_data),
    .wr_en   (lw_we),
    .wr_addr (s1_reg_idx),
    .wr_data (instr_time_r)
  );

  rddp_table #(.DEPTH(NUM_REGS), .WIDTH(rddp_pkg::COUNT_W)) u_tail_hits (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_reg_idx),
    .rd_data (tail_rd_data),
    .wr_en   (s1_adv && tail_hit),
    .wr_addr (s1_reg_idx),
    .wr_data (tail_cnt_inc)
  );

  rddp_table #(.DEPTH(HIST_BINS), .WIDTH(rddp_pkg::COUNT_W)) u_histogram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s1_adv),
    .rd_addr (s2_nxt.hist_addr),
    .rd_data (hist_rd_data),
    .wr_en   (out_fire && s2_r.hist_inc),
    .wr_addr (s2_r.hist_addr),
    .wr_data (rddp_pkg::sat_inc32(hist_rd_data))
  );

  // Stage one: distance, tail decision and table updates.
  assign diff = instr_time_r - lw_rd_data;
  assign dist_sat = (diff > rddp_pkg::TIME_W'(max_spacing_r)) ? max_spacing_r
                                                              : diff[rddp_pkg::SPACING_W-1:0];
  assign thr  = rddp_pkg::tail_threshold(max_spacing_r);
  assign slot = (32'(dist_sat) >= HIST_BINS) ? HIST_AW'(HIST_BINS - 1) : HIST_AW'(dist_sat);
  assign tail_cnt_inc = rddp_pkg::sat_inc32(tail_rd_data);

  // The tracked register always moves on its own hit; another takes over on more hits,
  // or on equal hits when its index is higher.
  assign best_upd = (s1_reg_idx == best_reg_r) || (tail_cnt_inc > best_cnt_r) ||
                    ((tail_cnt_inc == best_cnt_r) && (s1_reg_idx > best_reg_r));

  always_comb begin
    s2_nxt            = '0;
    tail_hit          = 1'b0;
    lw_we             = 1'b0;
    instr_time_nxt    = instr_time_r;
    best_reg_nxt      = best_reg_r;
    best_cnt_nxt      = best_cnt_r;
    case (s1_r.mode)
      rddp_pkg::MODE_SRC_READ: begin
        if (s1_reg_ok) begin
          s2_nxt.distance  = dist_sat;
          s2_nxt.hist_inc  = 1'b1;
          s2_nxt.hist_addr = slot;
          tail_hit         = dist_sat > thr;
          s2_nxt.is_tail   = tail_hit;
        end
      end
      rddp_pkg::MODE_DST_WRITE: begin
        lw_we = s1_adv && s1_reg_ok;
      end
      rddp_pkg::MODE_TICK: begin
        if (!(&instr_time_r)) begin
          instr_time_nxt = instr_time_r + rddp_pkg::TIME_W'(1);
        end
      end
      rddp_pkg::MODE_READ_BIN: begin
        s2_nxt.hist_rd   = s1_bin_ok;
        s2_nxt.hist_addr = HIST_AW'(s1_r.bin_index);
      end
      rddp_pkg::MODE_READ_TAIL: begin
        if (s1_reg_ok) begin
          s2_nxt.read_value = tail_rd_data;
        end
      end
      default: begin
      end
    endcase
    if (tail_hit && best_upd) begin
      best_reg_nxt = s1_reg_idx;
      best_cnt_nxt = tail_cnt_inc;
    end
    s2_nxt.best_reg = best_reg_nxt;
    s2_nxt.best_cnt = best_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_spacing_r <= rddp_pkg::MAX_SPACING_RST;
      instr_time_r  <= '0;
      best_reg_r    <= REG_AW'(NUM_REGS - 1);
      best_cnt_r    <= '0;
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_spacing_r <= cfg_wr_data;
      end
      if (s1_adv) begin
        instr_time_r <= instr_time_nxt;
        best_reg_r   <= best_reg_nxt;
        best_cnt_r   <= best_cnt_nxt;
      end
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage two is the output register; a bin read is taken from the histogram port.
  always_comb begin
    out_data.distance       = s2_r.distance;
    out_data.is_tail        = s2_r.is_tail;
    out_data.read_value     = s2_r.hist_rd ? hist_rd_data : s2_r.read_value;
    out_data.top_tail_reg   = rddp_pkg::REG_W'(s2_r.best_reg);
    out_data.top_tail_count = s2_r.best_cnt;
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with stage one empty");

  a_best_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> best_cnt_r >= $past(best_cnt_r))
    else $error("top tail count decreased");

  a_tail_hit_sets_best: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && tail_hit) |=> best_cnt_r != '0)
    else $error("tail hit left top tail count at zero");

  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> instr_time_r >= $past(instr_time_r))
    else $error("instruction counter went backward");
`endif

endmodule

// File: dv/register_dependency_distance_profiler_tb.sv
// Self-checking testbench for the register dependency distance profiler.
module register_dependency_distance_profiler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 30;
  localparam logic [rddp_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [rddp_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rddp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rddp_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [rddp_pkg::SPACING_W-1:0] cfg_wr_data = '0;

  register_dependency_distance_profiler u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Shadow copy of the profiler state.
  logic [rddp_pkg::SPACING_W-1:0] spacing_limit;
  logic [rddp_pkg::TIME_W-1:0]    instr_clock;
  logic [rddp_pkg::TIME_W-1:0]    last_write_at [rddp_pkg::NUM_REGS_DEF];
  logic [rddp_pkg::COUNT_W-1:0]   distance_bins [rddp_pkg::HIST_BINS_DEF];
  logic [rddp_pkg::COUNT_W-1:0]   tail_count    [rddp_pkg::NUM_REGS_DEF];
  logic [rddp_pkg::REG_W-1:0]     leader_reg;
  logic [rddp_pkg::COUNT_W-1:0]   leader_count;

  rddp_pkg::out_item_t pending_profiles[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int tail_events = 0;
  int cycle_count = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_profiles.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [rddp_pkg::COUNT_W-1:0] got,
                             input logic [rddp_pkg::COUNT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin : check_results
    rddp_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_profiles.size() == 0) begin
        report_mismatch($sformatf("transaction with nothing outstanding: %0h", out_data));
      end else begin
        want = pending_profiles.pop_front();
        check_field("distance", rddp_pkg::COUNT_W'(out_data.distance),
                    rddp_pkg::COUNT_W'(want.distance));
        check_field("is_tail", rddp_pkg::COUNT_W'(out_data.is_tail),
                    rddp_pkg::COUNT_W'(want.is_tail));
        check_field("read_value", out_data.read_value, want.read_value);
        check_field("top_tail_reg", rddp_pkg::COUNT_W'(out_data.top_tail_reg),
                    rddp_pkg::COUNT_W'(want.top_tail_reg));
        check_field("top_tail_count", out_data.top_tail_count, want.top_tail_count);
        results_seen++;
      end
    end
  end

  function automatic void reset_profile();
    spacing_limit = rddp_pkg::MAX_SPACING_RST;
    instr_clock = '0;
    foreach (last_write_at[i]) last_write_at[i] = '0;
    foreach (tail_count[i]) tail_count[i] = '0;
    foreach (distance_bins[i]) distance_bins[i] = '0;
    leader_reg = rddp_pkg::REG_W'(rddp_pkg::NUM_REGS_DEF - 1);
    leader_count = '0;
  endfunction

  // Applies one event to the shadow state and returns the result it must produce.
  function automatic rddp_pkg::out_item_t profile_event(input rddp_pkg::in_item_t ev);
    rddp_pkg::out_item_t res;
    logic [rddp_pkg::TIME_W-1:0] gap;
    logic [rddp_pkg::COUNT_W-1:0] hits;
    int threshold;
    res = '0;
    threshold = (int'(spacing_limit) / 5) * 4;
    case (ev.mode)
      rddp_pkg::MODE_SRC_READ: begin
        gap = instr_clock - last_write_at[ev.reg_index];
        if (gap > rddp_pkg::TIME_W'(spacing_limit)) gap = rddp_pkg::TIME_W'(spacing_limit);
        if (distance_bins[gap] != '1) distance_bins[gap] = distance_bins[gap] + 1;
        if (gap > rddp_pkg::TIME_W'(threshold)) begin
          hits = tail_count[ev.reg_index];
          if (hits != '1) hits = hits + 1;
          tail_count[ev.reg_index] = hits;
          // The current leader always follows its own count; others must beat it
          // or tie it from a higher index.
          if (ev.reg_index == leader_reg || hits > leader_count ||
              (hits == leader_count && ev.reg_index > leader_reg)) begin
            leader_reg = ev.reg_index;
            leader_count = hits;
          end
          res.is_tail = 1'b1;
          tail_events++;
        end
        res.distance = gap[rddp_pkg::SPACING_W-1:0];
      end
      rddp_pkg::MODE_DST_WRITE: last_write_at[ev.reg_index] = instr_clock;
      rddp_pkg::MODE_TICK: if (instr_clock != '1) instr_clock = instr_clock + 1;
      rddp_pkg::MODE_READ_BIN: res.read_value = distance_bins[ev.bin_index];
      rddp_pkg::MODE_READ_TAIL: res.read_value = tail_count[ev.reg_index];
      default: ;
    endcase
    res.top_tail_reg = leader_reg;
    res.top_tail_count = leader_count;
    return res;
  endfunction

  function automatic rddp_pkg::in_item_t mk(input logic [rddp_pkg::MODE_W-1:0] m,
                                            input int r, input int b);
    rddp_pkg::in_item_t ev;
    ev.mode = m;
    ev.reg_index = rddp_pkg::REG_W'(r);
    ev.bin_index = rddp_pkg::BIN_W'(b);
    return ev;
  endfunction

  function automatic rddp_pkg::in_item_t rand_event();
    rddp_pkg::in_item_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    // A small register set gives repeated tail hits and ties at both index ends.
    if ($urandom_range(0, 1) == 0) begin
      ev.reg_index = $urandom_range(0, 1) ? rddp_pkg::REG_W'($urandom_range(0, 3))
                                           : rddp_pkg::REG_W'($urandom_range(60, 63));
    end else begin
      ev.reg_index = rddp_pkg::REG_W'($urandom_range(0, rddp_pkg::NUM_REGS_DEF - 1));
    end
    ev.bin_index = ($urandom_range(0, 9) < 7) ?
                   rddp_pkg::BIN_W'($urandom_range(0, spacing_limit)) :
                   rddp_pkg::BIN_W'($urandom_range(0, rddp_pkg::HIST_BINS_DEF - 1));
    if (pick < 30) ev.mode = rddp_pkg::MODE_SRC_READ;
    else if (pick < 45) ev.mode = rddp_pkg::MODE_DST_WRITE;
    else if (pick < 80) ev.mode = rddp_pkg::MODE_TICK;
    else if (pick < 88) ev.mode = rddp_pkg::MODE_READ_BIN;
    else if (pick < 95) ev.mode = rddp_pkg::MODE_READ_TAIL;
    else ev.mode = rddp_pkg::MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    return ev;
  endfunction

  task automatic send_event(input rddp_pkg::in_item_t ev);
    rddp_pkg::out_item_t expected;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected = profile_event(ev);
    pending_profiles.insert(pending_profiles.size(), expected);
    accepted_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [rddp_pkg::SPACING_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    spacing_limit = value;
  endtask

  task automatic test_readback_and_distance();
    send_event(mk(rddp_pkg::MODE_READ_BIN, 0, 0));
    send_event(mk(rddp_pkg::MODE_READ_BIN, 0, rddp_pkg::HIST_BINS_DEF - 1));
    send_event(mk(rddp_pkg::MODE_READ_TAIL, 0, 0));
    send_event(mk(rddp_pkg::MODE_READ_TAIL, rddp_pkg::NUM_REGS_DEF - 1, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, rddp_pkg::NUM_REGS_DEF - 1, 0));
    send_event(mk(rddp_pkg::MODE_DST_WRITE, 0, 0));
    send_event(mk(rddp_pkg::MODE_TICK, 0, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, 0, 0));
    send_event(mk(rddp_pkg::MODE_READ_BIN, 0, 0));
    send_event(mk(rddp_pkg::MODE_READ_BIN, 0, 1));
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      send_event(mk(rddp_pkg::MODE_W'(m), rddp_pkg::NUM_REGS_DEF - 1,
                    rddp_pkg::HIST_BINS_DEF - 1));
    end
  endtask

  // With a limit of 5 the tail threshold is 4, so a few ticks reach the tail.
  task automatic test_tail_ranking();
    write_spacing(rddp_pkg::SPACING_W'(5));
    repeat (5) send_event(mk(rddp_pkg::MODE_TICK, 0, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, 5, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, 10, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, 3, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, 3, 0));
    send_event(mk(rddp_pkg::MODE_DST_WRITE, 3, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, 3, 0));
    send_event(mk(rddp_pkg::MODE_READ_TAIL, 3, 0));
    send_event(mk(rddp_pkg::MODE_READ_BIN, 0, 5));
  endtask

  task automatic test_zero_spacing();
    write_spacing('0);
    send_event(mk(rddp_pkg::MODE_TICK, 0, 0));
    send_event(mk(rddp_pkg::MODE_SRC_READ, 40, 0));
    send_event(mk(rddp_pkg::MODE_READ_BIN, 0, 0));
  endtask

  task automatic test_random_traffic(input logic [rddp_pkg::SPACING_W-1:0] limit,
                                     input int idle, input int stall, input int count,
                                     input bit pause);
    write_spacing(limit);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      // Let the pipeline empty completely once before carrying on.
      if (pause && i == count / 2) wait_drained();
      send_event(rand_event());
    end
  endtask

  initial begin
    reset_profile();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_readback_and_distance();
    test_tail_ranking();
    test_zero_spacing();
    test_random_traffic(rddp_pkg::MAX_SPACING_RST, 0, 0, 260, 1'b0);
    test_random_traffic(rddp_pkg::SPACING_W'(127), 45, 0, 260, 1'b0);
    test_random_traffic(rddp_pkg::SPACING_W'(1), 0, 45, 260, 1'b0);
    test_random_traffic(rddp_pkg::SPACING_W'($urandom_range(2, 126)), 18, 18, 260, 1'b1);
    test_random_traffic(rddp_pkg::SPACING_W'(20), 0, 0, 260, 1'b0);
    idle_pct = 0;
    stall_pct = 0;
    wait_drained();

    $display("Covered %0d transactions and %0d results over several spacing limits,",
             accepted_count, results_seen);
    $display("including %0d tail hits, with sender gaps and receiver stalls mixed in.",
             tail_events);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", error_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: register_dependency_distance_profiler.f
rtl/rddp_pkg.sv
rtl/rddp_table.sv
rtl/register_dependency_distance_profiler.sv
dv/register_dependency_distance_profiler_tb.sv
